// ===== rtl/core/acsf_pkg.sv =====
package acsf_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_CSI      = 8'h9B;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0] BYTE_QUERY    = 8'h3F;
    localparam logic [7:0] BYTE_SEMI     = 8'h3B;
    localparam logic [7:0] BYTE_DIGIT_LO = 8'h30;
    localparam logic [7:0] BYTE_DIGIT_HI = 8'h39;
    localparam logic [7:0] BYTE_FINAL_LO = 8'h40;
    localparam logic [7:0] BYTE_FINAL_HI = 8'h7E;

    // One queue entry holds every word caused by one input byte (at most two).
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;
        logic       valid0;
        logic       eot;
    } acsf_entry_t;

    typedef struct packed {
        logic        push;
        acsf_entry_t entry;
    } acsf_wr_t;

    typedef struct packed {
        logic        not_empty;
        acsf_entry_t entry;
    } acsf_rd_t;

endpackage

// ===== rtl/core/acsf_front.sv =====
module acsf_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  logic [7:0]      s_in_byte,
    input  logic            s_in_last,
    output acsf_pkg::acsf_wr_t wr
);
    import acsf_pkg::*;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_PARAMS = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    mode_t       mode_reg;
    mode_t       mode_next;
    mode_t       text_mode;
    mode_t       parsed_mode;
    logic        text_emit;
    logic        use_text;
    logic        lead_query;
    logic        tail_query;
    logic        any_word;
    logic        is_param;
    logic        is_final;
    logic        accept;
    acsf_entry_t entry;

    assign accept   = s_valid && s_ready;
    assign is_param = ((s_in_byte >= BYTE_DIGIT_LO) && (s_in_byte <= BYTE_DIGIT_HI))
                      || (s_in_byte == BYTE_SEMI);
    assign is_final = (s_in_byte >= BYTE_FINAL_LO) && (s_in_byte <= BYTE_FINAL_HI);

    // Plain text handling of the current byte, used by several modes.
    always_comb begin
        text_emit = 1'b0;
        unique case (s_in_byte)
            BYTE_ESC:   text_mode = MODE_ESC;
            BYTE_CSI:   text_mode = MODE_PARAMS;
            BYTE_QUERY: text_mode = MODE_QUERY;
            default: begin
                text_mode = MODE_TEXT;
                text_emit = 1'b1;
            end
        endcase
    end

    always_comb begin
        use_text    = 1'b0;
        lead_query  = 1'b0;
        parsed_mode = mode_reg;
        unique case (mode_reg)
            MODE_ESC: begin
                if (s_in_byte == BYTE_LBRACKET) begin
                    parsed_mode = MODE_PARAMS;
                end else begin
                    use_text = 1'b1;
                end
            end
            MODE_PARAMS: begin
                if (is_param) begin
                    parsed_mode = MODE_PARAMS;
                end else if (is_final) begin
                    parsed_mode = MODE_TEXT;
                end else begin
                    use_text = 1'b1;
                end
            end
            MODE_QUERY: begin
                if (s_in_byte == BYTE_LBRACKET) begin
                    parsed_mode = MODE_PARAMS;
                end else begin
                    lead_query = 1'b1;
                    use_text   = 1'b1;
                end
            end
            default: use_text = 1'b1;
        endcase
        if (use_text) begin
            parsed_mode = text_mode;
        end
    end

    // A held question mark at end of text is flushed. An emitted text byte
    // always returns the parser to normal text mode, so at most two words result.
    always_comb begin
        tail_query   = s_in_last && (parsed_mode == MODE_QUERY);
        any_word     = lead_query || (use_text && text_emit) || tail_query;
        entry.byte0  = (use_text && text_emit && !lead_query) ? s_in_byte : BYTE_QUERY;
        entry.byte1  = (use_text && text_emit) ? s_in_byte : BYTE_QUERY;
        entry.two    = lead_query && ((use_text && text_emit) || tail_query);
        entry.valid0 = any_word;
        entry.eot    = s_in_last;
        if (!any_word) begin
            entry.byte0 = 8'h00;
        end
        wr.entry = entry;
        wr.push  = accept && (any_word || s_in_last);
        mode_next = s_in_last ? MODE_TEXT : parsed_mode;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_TEXT;
        end else if (accept) begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ===== rtl/core/acsf_queue.sv =====
module acsf_queue #(
    parameter int unsigned DEPTH = acsf_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  acsf_pkg::acsf_wr_t wr,
    output logic               full,
    input  logic               pop,
    output acsf_pkg::acsf_rd_t rd
);
    import acsf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    acsf_entry_t        slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push_fire;
    logic               pop_fire;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign push_fire = wr.push && !full;
    assign pop_fire  = pop && (count_reg != '0);

    assign rd.not_empty = (count_reg != '0);
    assign rd.entry     = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 1'b1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slots[wr_ptr_reg] <= wr.entry;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_fire && !pop_fire) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow the queue");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_fire && !push_fire) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop without push did not shrink the queue");

endmodule

// ===== rtl/core/acsf_back.sv =====
module acsf_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  acsf_pkg::acsf_rd_t rd,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_byte_valid,
    output logic               m_end_of_text
);
    import acsf_pkg::*;

    // Set while the second word of a two-word entry is on the output.
    logic half_reg;
    logic half_next;
    logic last_of_entry;
    logic word_fire;

    assign m_valid       = rd.not_empty;
    assign last_of_entry = half_reg || !rd.entry.two;
    assign word_fire     = m_valid && m_ready;
    assign pop           = word_fire && last_of_entry;

    assign m_out_byte    = half_reg ? rd.entry.byte1 : rd.entry.byte0;
    assign m_byte_valid  = half_reg ? 1'b1 : rd.entry.valid0;
    assign m_end_of_text = rd.entry.eot && last_of_entry;

    always_comb begin
        half_next = half_reg;
        if (word_fire) begin
            half_next = !last_of_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= 1'b0;
        end else begin
            half_reg <= half_next;
        end
    end

    a_half_two: assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg |-> (rd.not_empty && rd.entry.two))
        else $error("second word selected on an entry without one");

    a_first_then_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (word_fire && rd.entry.two && !half_reg) |=> (half_reg && !$past(pop)))
        else $error("two-word entry left before its second word");

endmodule

// ===== rtl/core/ansi_csi_escape_stripper_unit.sv =====
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    s_in_byte[7:0], s_in_last
// m_       out  m_valid/m_ready    m_out_byte[7:0], m_byte_valid, m_end_of_text
//
// One byte is accepted per cycle while the entry queue has room; the parser
// classifies it in the same cycle and queues the words it causes, at most two.
// The output side drains one word per cycle while m_ready is high, so a byte that
// yields two words holds the output for both; words reach it from the queue slots.
// aresetn is synchronous, active low, and returns the parser to normal text.
// Either side may stall without blocking the other until the queue fills or empties.
module ansi_csi_escape_stripper_unit #(
    parameter int unsigned QUEUE_DEPTH = acsf_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_end_of_text
);
    import acsf_pkg::*;

    acsf_wr_t wr;
    acsf_rd_t rd;
    logic     full;
    logic     pop;

    assign s_ready = !full;

    acsf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .wr        (wr)
    );

    acsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .full    (full),
        .pop     (pop),
        .rd      (rd)
    );

    acsf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rd            (rd),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_end_of_text (m_end_of_text)
    );

endmodule
